### rtl/core/plm_pkg.sv
// Shared constants, request codes and control types for the posting list merge/prune block.
`timescale 1ns / 1ps
package plm_pkg;

  localparam int DEL_DEPTH = 1024;
  localparam int DEL_AW    = (DEL_DEPTH > 1) ? $clog2(DEL_DEPTH) : 1;
  localparam int PTR_W     = $clog2(DEL_DEPTH + 1);
  localparam int GROUP_MAX = 16777216;
  localparam int CNT_W     = 25;
  localparam int ID_W      = 32;
  localparam int PURGE_W   = 31;
  localparam int MODE_W    = 3;

  localparam logic signed [ID_W-1:0] POS_INIT = 32'sh7fffffff;
  localparam logic signed [ID_W-1:0] NEG_INIT = -32'sh7fffffff;

  // Configuration register indexes
  localparam logic REG_POS_PURGE = 1'b0;
  localparam logic REG_NEG_PURGE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_BEGIN  = 3'd2,
    MODE_NEW    = 3'd3,
    MODE_OLD    = 3'd4,
    MODE_END    = 3'd5
  } mode_t;

  typedef struct packed {
    logic accept;  // take the request at the input ports
    logic step;    // move the active pointer one entry
    logic finish;  // resolve the old id and post its result
  } plm_cmd_t;

  typedef struct packed {
    logic walk_go;  // current entry lies beyond the id, keep walking
  } plm_sts_t;

endpackage

### rtl/core/plm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module plm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/plm_ctrl.sv
// Controller: accepts requests and sequences the deletion-list walk for old ids.
`timescale 1ns / 1ps
module plm_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plm_pkg::MODE_W-1:0]    in_mode,
  input  plm_pkg::plm_sts_t             sts,
  output plm_pkg::plm_cmd_t             cmd,
  output logic                          busy
);
  import plm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (mode_t'(in_mode) == MODE_OLD) begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (sts.walk_go) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r == ST_LOOK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/plm_dp.sv
// Datapath: deletion store, walk pointers, group thresholds, kept count and result registers.
`timescale 1ns / 1ps
module plm_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plm_pkg::plm_cmd_t                 cmd,
  output plm_pkg::plm_sts_t                 sts,
  input  logic [plm_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [plm_pkg::ID_W-1:0]   in_message_id,
  input  logic [plm_pkg::PURGE_W-1:0]       pos_purge,
  input  logic signed [plm_pkg::ID_W-1:0]   neg_purge,
  output logic                              out_valid,
  output logic                              out_kept,
  output logic                              out_dropped,
  output logic signed [plm_pkg::ID_W-1:0]   out_kept_id,
  output logic [plm_pkg::CNT_W-1:0]         out_group_count,
  output logic                              out_single_inline,
  output logic                              out_group_done
);
  import plm_pkg::*;

  logic [PTR_W-1:0]       del_cnt_r, del_cnt_nxt;
  logic [PTR_W-1:0]       low_r, low_nxt;
  logic [PTR_W-1:0]       high_r, high_nxt;
  logic signed [ID_W-1:0] pos_lim_r, pos_lim_nxt;
  logic signed [ID_W-1:0] neg_lim_r, neg_lim_nxt;
  logic [CNT_W-1:0]       kept_cnt_r, kept_cnt_nxt;
  logic signed [ID_W-1:0] id_r, id_nxt;

  logic                   valid_r, valid_nxt;
  logic                   kept_r, kept_nxt;
  logic                   dropped_r, dropped_nxt;
  logic signed [ID_W-1:0] kid_r, kid_nxt;
  logic [CNT_W-1:0]       gcnt_r, gcnt_nxt;
  logic                   single_r, single_nxt;
  logic                   done_r, done_nxt;

  logic                   ram_we;
  logic [DEL_AW-1:0]      ram_waddr;
  logic [DEL_AW-1:0]      ram_raddr;
  logic [ID_W-1:0]        ram_rdata;
  logic signed [ID_W-1:0] entry;
  logic                   pos_side;
  logic                   pos_sel;
  logic                   have_ent;
  logic                   drop;
  logic [CNT_W-1:0]       cnt_inc;
  logic [PTR_W-1:0]       high_m1;

  plm_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEL_DEPTH)
  ) u_del_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_message_id),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign entry    = $signed(ram_rdata);
  assign pos_side = (id_r > 0);
  assign have_ent = (low_r < high_r);
  assign cnt_inc  = (kept_cnt_r < CNT_W'(GROUP_MAX)) ? kept_cnt_r + 1'b1 : kept_cnt_r;

  // Walk down from the top for positives, up from the bottom for the rest.
  assign sts.walk_go = have_ent && (pos_side ? (entry > id_r) : (entry < id_r));

  assign drop = (have_ent && (entry == id_r)) ||
                (pos_side ? ((id_r <= $signed({1'b0, pos_purge})) || (id_r >= pos_lim_r))
                          : ((id_r >= neg_purge) || (id_r <= neg_lim_r)));

  assign ram_we    = cmd.accept && (mode_t'(in_mode) == MODE_APPEND) &&
                     (del_cnt_r < PTR_W'(DEL_DEPTH));
  assign ram_waddr = del_cnt_r[DEL_AW-1:0];

  // Address the entry for the next look from the pointers after this cycle.
  assign pos_sel   = cmd.accept ? (in_message_id > 0) : pos_side;
  assign high_m1   = high_nxt - 1'b1;
  assign ram_raddr = pos_sel ? high_m1[DEL_AW-1:0] : low_nxt[DEL_AW-1:0];

  always_comb begin
    del_cnt_nxt  = del_cnt_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    pos_lim_nxt  = pos_lim_r;
    neg_lim_nxt  = neg_lim_r;
    kept_cnt_nxt = kept_cnt_r;
    id_nxt       = id_r;
    valid_nxt    = 1'b0;
    kept_nxt     = kept_r;
    dropped_nxt  = dropped_r;
    kid_nxt      = kid_r;
    gcnt_nxt     = gcnt_r;
    single_nxt   = single_r;
    done_nxt     = done_r;

    if (cmd.accept) begin
      id_nxt      = in_message_id;
      kept_nxt    = 1'b0;
      dropped_nxt = 1'b0;
      kid_nxt     = '0;
      gcnt_nxt    = '0;
      single_nxt  = 1'b0;
      done_nxt    = 1'b0;
      valid_nxt   = (mode_t'(in_mode) != MODE_OLD);
      case (mode_t'(in_mode))
        MODE_CLEAR: del_cnt_nxt = '0;
        MODE_APPEND: begin
          if (del_cnt_r < PTR_W'(DEL_DEPTH)) begin
            del_cnt_nxt = del_cnt_r + 1'b1;
          end
        end
        MODE_BEGIN: begin
          low_nxt      = '0;
          high_nxt     = del_cnt_r;
          pos_lim_nxt  = POS_INIT;
          neg_lim_nxt  = NEG_INIT;
          kept_cnt_nxt = '0;
        end
        MODE_NEW: begin
          if (in_message_id > 0) begin
            pos_lim_nxt = in_message_id;
          end else begin
            neg_lim_nxt = in_message_id;
          end
          kept_nxt     = 1'b1;
          kid_nxt      = in_message_id;
          kept_cnt_nxt = cnt_inc;
        end
        MODE_END: begin
          done_nxt   = 1'b1;
          gcnt_nxt   = kept_cnt_r;
          single_nxt = (kept_cnt_r == CNT_W'(1));
        end
        default: ;
      endcase
    end

    if (cmd.step) begin
      if (pos_side) begin
        high_nxt = high_r - 1'b1;
      end else begin
        low_nxt = low_r + 1'b1;
      end
    end

    if (cmd.finish) begin
      valid_nxt   = 1'b1;
      dropped_nxt = drop;
      kept_nxt    = !drop;
      kid_nxt     = drop ? '0 : id_r;
      if (!drop) begin
        kept_cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      del_cnt_r  <= '0;
      low_r      <= '0;
      high_r     <= '0;
      pos_lim_r  <= POS_INIT;
      neg_lim_r  <= NEG_INIT;
      kept_cnt_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      del_cnt_r  <= del_cnt_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      pos_lim_r  <= pos_lim_nxt;
      neg_lim_r  <= neg_lim_nxt;
      kept_cnt_r <= kept_cnt_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    kept_r    <= kept_nxt;
    dropped_r <= dropped_nxt;
    kid_r     <= kid_nxt;
    gcnt_r    <= gcnt_nxt;
    single_r  <= single_nxt;
    done_r    <= done_nxt;
  end

  assign out_valid         = valid_r;
  assign out_kept          = kept_r;
  assign out_dropped       = dropped_r;
  assign out_kept_id       = kid_r;
  assign out_group_count   = gcnt_r;
  assign out_single_inline = single_r;
  assign out_group_done    = done_r;

endmodule

### rtl/core/posting_list_merge_prune.sv
// Top level: posting list merge/prune with APB purge-limit registers.
//
//   channel   ports                              handshake
//   request   start, busy, in_mode, in_message_id   taken when start && !busy
//   result    out_valid, out_*                   one-cycle strobe, no backpressure
//   config    psel, penable, pwrite, paddr, ...  APB, pready tied high
//
// Every request but an old id leaves busy low, and its result shows the cycle after.
// An old id holds busy while the pointer walk passes the deletion entries and the id
// is resolved, one RAM read per cycle; the pointers only move forward within a group.
// Reset (rst_n, synchronous) empties the deletion list and restores the group
// thresholds; the store itself is not cleared.
`timescale 1ns / 1ps
module posting_list_merge_prune (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [plm_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [plm_pkg::ID_W-1:0]   in_message_id,
  output logic                              out_valid,
  output logic                              out_kept,
  output logic                              out_dropped,
  output logic signed [plm_pkg::ID_W-1:0]   out_kept_id,
  output logic [plm_pkg::CNT_W-1:0]         out_group_count,
  output logic                              out_single_inline,
  output logic                              out_group_done,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import plm_pkg::*;

  plm_cmd_t               cmd;
  plm_sts_t               sts;
  logic [PURGE_W-1:0]     pos_purge_r, pos_purge_nxt;
  logic signed [ID_W-1:0] neg_purge_r, neg_purge_nxt;
  logic                   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    pos_purge_nxt = pos_purge_r;
    neg_purge_nxt = neg_purge_r;
    if (wr_en) begin
      case (paddr[2])
        REG_POS_PURGE: pos_purge_nxt = pwdata[PURGE_W-1:0];
        REG_NEG_PURGE: neg_purge_nxt = $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POS_PURGE: prdata = {1'b0, pos_purge_r};
      REG_NEG_PURGE: prdata = neg_purge_r;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_purge_r <= '0;
      neg_purge_r <= '0;
    end else begin
      pos_purge_r <= pos_purge_nxt;
      neg_purge_r <= neg_purge_nxt;
    end
  end

  plm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  plm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_message_id     (in_message_id),
    .pos_purge         (pos_purge_r),
    .neg_purge         (neg_purge_r),
    .out_valid         (out_valid),
    .out_kept          (out_kept),
    .out_dropped       (out_dropped),
    .out_kept_id       (out_kept_id),
    .out_group_count   (out_group_count),
    .out_single_inline (out_single_inline),
    .out_group_done    (out_group_done)
  );

endmodule
